### src/pnm_hp_pkg.sv
// ----------------------------------------------------------------------------
// pnm_hp_pkg: shared types and constants of the pnm header parser
// Holds the transfer payload types, character codes and image kind codes.
// ----------------------------------------------------------------------------
package pnm_hp_pkg;

  // width of the parsed numbers
  localparam int unsigned ValueBits = 16;

  // character codes used by the header syntax
  localparam logic [7:0] CharP     = 8'h50;  // 'P'
  localparam logic [7:0] Char0     = 8'h30;  // '0'
  localparam logic [7:0] Char4     = 8'h34;  // '4'
  localparam logic [7:0] Char6     = 8'h36;  // '6'
  localparam logic [7:0] Char9     = 8'h39;  // '9'
  localparam logic [7:0] CharHash  = 8'h23;  // '#'
  localparam logic [7:0] CharNl    = 8'h0a;  // newline
  localparam logic [7:0] CharSpace = 8'h20;  // space
  localparam logic [7:0] CharTab   = 8'h09;  // tab

  // decimal radix
  localparam int unsigned Radix = 10;

  // image kind codes
  localparam logic [1:0] KindBitmap = 2'd0;
  localparam logic [1:0] KindGray   = 2'd1;
  localparam logic [1:0] KindColor  = 2'd2;

  // header field index codes
  localparam logic [1:0] FieldWidth  = 2'd0;
  localparam logic [1:0] FieldHeight = 2'd1;
  localparam logic [1:0] FieldMax    = 2'd2;

  // input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } pnm_in_t;

  // result transfer payload
  typedef struct packed {
    logic                 header_ok;
    logic [1:0]           image_kind;
    logic [ValueBits-1:0] image_width;
    logic [ValueBits-1:0] image_height;
    logic [ValueBits-1:0] max_value;
    logic                 value_saturated;
  } pnm_out_t;

endpackage

### src/pnm_header_parser.sv
// ----------------------------------------------------------------------------
// pnm_header_parser: binary pnm header parser, one byte per cycle when not stalled
// Parses magic, width, height and (P5/P6 only) max value of a P4/P5/P6 header and gives
// one result per stream.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (pnm_in_t)
//   out     | output    | out_valid_o / out_stall_i| out_data_o (pnm_out_t)
//
// One byte is taken per cycle while the input is not stalled; the parse state
// updates in the cycle of the transfer and a result is registered before it shows.
// A two-entry output (result register plus skid register) sets the rate: the
// input stalls only while the skid register is occupied.
// Reset returns the parser to the start of a stream; end_of_stream does too.
// ----------------------------------------------------------------------------
module pnm_header_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pnm_hp_pkg::pnm_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pnm_hp_pkg::pnm_out_t out_data_o
);

  localparam int unsigned VB   = pnm_hp_pkg::ValueBits;
  localparam int unsigned AccW = VB + 4;
  localparam logic [AccW-1:0] VMaxWide = AccW'({VB{1'b1}});

  typedef enum logic [2:0] {
    ST_LEAD,
    ST_LEAD_CMT,
    ST_MAGIC,
    ST_SEP,
    ST_CMT,
    ST_NUM,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      field_q, field_d;
  logic [VB-1:0]   acc_q, acc_d;
  logic [1:0]      kind_q, kind_d;
  logic [VB-1:0]   width_q, width_d;
  logic [VB-1:0]   height_q, height_d;
  logic            ovf_q, ovf_d;

  logic            out_valid_q, skid_valid_q;
  pnm_hp_pkg::pnm_out_t out_q, skid_q;

  logic            in_fire;
  logic            res_valid;
  logic            res_ok;
  logic [VB-1:0]   res_last;
  pnm_hp_pkg::pnm_out_t res;

  logic [7:0]      ch;
  logic            is_digit, is_space;
  logic [3:0]      digit;
  logic [AccW-1:0] acc_wide;
  logic [1:0]      last_field;
  logic            do_sep;
  logic [1:0]      sep_field;

  assign in_fire = in_valid_i && !in_stall_o;
  assign ch      = in_data_i.data_byte;

  // byte classes and decimal accumulate
  assign is_digit   = (ch >= pnm_hp_pkg::Char0) && (ch <= pnm_hp_pkg::Char9);
  assign is_space   = (ch == pnm_hp_pkg::CharSpace) || (ch == pnm_hp_pkg::CharTab) ||
                      (ch == pnm_hp_pkg::CharNl);
  assign digit      = 4'(ch - pnm_hp_pkg::Char0);
  assign acc_wide   = AccW'(acc_q) * AccW'(pnm_hp_pkg::Radix) + AccW'(digit);
  assign last_field = (kind_q == pnm_hp_pkg::KindBitmap) ? pnm_hp_pkg::FieldHeight
                                                         : pnm_hp_pkg::FieldMax;

  // parse step for one transfer
  always_comb begin
    state_d   = state_q;
    field_d   = field_q;
    acc_d     = acc_q;
    kind_d    = kind_q;
    width_d   = width_q;
    height_d  = height_q;
    ovf_d     = ovf_q;
    res_valid = 1'b0;
    res_ok    = 1'b0;
    res_last  = acc_q;
    do_sep    = 1'b0;
    sep_field = field_q;
    if (in_fire) begin
      if (in_data_i.end_of_stream) begin
        // end of stream: report unless done, then restart
        if (state_q != ST_DONE) begin
          res_valid = 1'b1;
          res_ok    = (state_q == ST_NUM) && (field_q == last_field);
        end
        state_d  = ST_LEAD;
        field_d  = pnm_hp_pkg::FieldWidth;
        acc_d    = '0;
        kind_d   = pnm_hp_pkg::KindBitmap;
        width_d  = '0;
        height_d = '0;
        ovf_d    = 1'b0;
      end else begin
        unique case (state_q)
          ST_LEAD: begin
            if (ch == pnm_hp_pkg::CharHash) begin
              state_d = ST_LEAD_CMT;
            end else if (ch == pnm_hp_pkg::CharP) begin
              state_d = ST_MAGIC;
            end else begin
              res_valid = 1'b1;
              state_d   = ST_DONE;
            end
          end
          ST_LEAD_CMT: begin
            if (ch == pnm_hp_pkg::CharNl) begin
              state_d = ST_LEAD;
            end
          end
          ST_MAGIC: begin
            if ((ch >= pnm_hp_pkg::Char4) && (ch <= pnm_hp_pkg::Char6)) begin
              kind_d  = 2'(ch - pnm_hp_pkg::Char4);
              field_d = pnm_hp_pkg::FieldWidth;
              state_d = ST_SEP;
            end else begin
              res_valid = 1'b1;
              state_d   = ST_DONE;
            end
          end
          ST_CMT: begin
            if (ch == pnm_hp_pkg::CharNl) begin
              state_d = ST_SEP;
            end
          end
          ST_NUM: begin
            if (is_digit) begin
              if (acc_wide > VMaxWide) begin
                acc_d = VB'(VMaxWide);
                ovf_d = 1'b1;
              end else begin
                acc_d = VB'(acc_wide);
              end
            end else if (field_q == last_field) begin
              res_valid = 1'b1;
              res_ok    = 1'b1;
              state_d   = ST_DONE;
            end else begin
              // number ends; the byte is then taken as a separator
              if (field_q == pnm_hp_pkg::FieldWidth) begin
                width_d = acc_q;
              end else begin
                height_d = acc_q;
              end
              acc_d     = '0;
              sep_field = field_q + 2'd1;
              do_sep    = 1'b1;
            end
          end
          ST_SEP: begin
            do_sep = 1'b1;
          end
          ST_DONE: begin
          end
          default: begin
          end
        endcase

        // separator handling between fields
        if (do_sep) begin
          field_d = sep_field;
          if (is_space) begin
            state_d = ST_SEP;
          end else if (ch == pnm_hp_pkg::CharHash) begin
            state_d = ST_CMT;
          end else if (is_digit) begin
            acc_d   = VB'(digit);
            state_d = ST_NUM;
          end else begin
            res_valid = 1'b1;
            state_d   = ST_DONE;
          end
        end
      end
    end
  end

  // result fields; a failure reports all zero
  always_comb begin
    res = '0;
    if (res_ok) begin
      res.header_ok       = 1'b1;
      res.image_kind      = kind_q;
      res.image_width     = width_q;
      res.value_saturated = ovf_q;
      if (kind_q == pnm_hp_pkg::KindBitmap) begin
        res.image_height = res_last;
        res.max_value    = '0;
      end else begin
        res.image_height = height_q;
        res.max_value    = res_last;
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LEAD;
      field_q  <= pnm_hp_pkg::FieldWidth;
      acc_q    <= '0;
      kind_q   <= pnm_hp_pkg::KindBitmap;
      width_q  <= '0;
      height_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      field_q  <= field_d;
      acc_q    <= acc_d;
      kind_q   <= kind_d;
      width_q  <= width_d;
      height_q <= height_d;
      ovf_q    <= ovf_d;
    end
  end

  // output register and skid register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output is empty");

  a_eos_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_stream) |=> (state_q == ST_LEAD && ovf_q == 1'b0))
    else $error("end of stream did not restart the parser");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.header_ok) |->
      (out_data_o.image_width == '0 && out_data_o.image_height == '0 &&
       out_data_o.max_value == '0 && out_data_o.image_kind == 2'd0 &&
       !out_data_o.value_saturated))
    else $error("failure result carries nonzero fields");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !(in_fire && in_data_i.end_of_stream)) |=> (state_q == ST_DONE))
    else $error("parser continued after giving a result");

endmodule

### tb/tb_pnm_header_parser.sv
// ----------------------------------------------------------------------------
// tb_pnm_header_parser: self-checking testbench of the pnm header parser
// Sends byte streams (short directed streams, then random well-formed,
// broken and noise streams, each closed by end_of_stream). A behavioral
// parser predicts one header result per stream, and the monitor compares
// every result transfer field by field. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_pnm_header_parser;
  import pnm_hp_pkg::*;

  // parser phases of the behavioral model; separator, comment and number
  // phases repeat once per header field in steps of three
  localparam int unsigned PhLead    = 0;
  localparam int unsigned PhLeadCmt = 1;
  localparam int unsigned PhMagic   = 2;
  localparam int unsigned PhSep     = 3;
  localparam int unsigned PhCmt     = 4;
  localparam int unsigned PhNum     = 5;
  localparam int unsigned PhDone    = 12;

  localparam logic [31:0] ValueMax   = (32'd1 << ValueBits) - 32'd1;
  localparam logic [7:0]  CharCr     = 8'h0d;
  localparam int unsigned ItemCount  = 1700;
  localparam int unsigned IdlePct    = 8;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    pnm_in_t item;
    bit      drain_first;  // hold off until every pending header has arrived
  } byte_slot_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pnm_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pnm_out_t out_data_o;

  byte_slot_t  byte_feed[$];
  logic [7:0]  stream_q[$];
  pnm_out_t    expected_headers[$];

  // behavioral parser state
  int unsigned st_phase;
  logic [31:0] st_value;
  logic [1:0]  st_kind;
  logic [31:0] st_width;
  logic [31:0] st_height;
  logic        st_sat;

  int unsigned errors       = 0;
  int unsigned in_count     = 0;
  int unsigned quiet_cycles = 0;
  logic        in_fire      = 1'b0;
  logic        calm;

  // no idling on either side for a stretch of the run
  assign calm = (in_count >= 700) && (in_count < 1100);

  pnm_header_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit is_dig(input logic [7:0] c);
    return (c >= Char0) && (c <= Char9);
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharNl);
  endfunction

  // ---------------------------------------------------------------------------
  // header prediction
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    st_phase  = PhLead;
    st_value  = '0;
    st_kind   = KindBitmap;
    st_width  = '0;
    st_height = '0;
    st_sat    = 1'b0;
  endtask

  task automatic finish_header(input bit good, input logic [31:0] last);
    pnm_out_t r;
    r = '0;
    if (good) begin
      r.header_ok       = 1'b1;
      r.image_kind      = st_kind;
      r.image_width     = st_width[ValueBits-1:0];
      r.value_saturated = st_sat;
      if (st_kind == KindBitmap) begin
        r.image_height = last[ValueBits-1:0];
      end else begin
        r.image_height = st_height[ValueBits-1:0];
        r.max_value    = last[ValueBits-1:0];
      end
    end
    expected_headers.push_back(r);
    st_phase = PhDone;
  endtask

  task automatic predict_header_result(input pnm_in_t item);
    logic [7:0]  c;
    int unsigned fld;
    int unsigned sub;
    int unsigned last_fld;
    bit          good;
    c = item.data_byte;
    // end of stream closes any open header and always restarts the parser
    if (item.end_of_stream) begin
      if (st_phase != PhDone) begin
        good = 1'b0;
        if (st_phase >= PhSep && st_phase < PhDone) begin
          fld      = (st_phase - PhSep) / 3;
          sub      = (st_phase - PhSep) % 3;
          last_fld = (st_kind == KindBitmap) ? FieldHeight : FieldMax;
          good     = (sub == 2) && (fld == last_fld);
        end
        finish_header(good, st_value);
      end
      clear_parser();
      return;
    end
    if (st_phase == PhDone) return;
    // leading comment lines, then the magic
    if (st_phase == PhLead) begin
      if (c == CharHash) st_phase = PhLeadCmt;
      else if (c == CharP) st_phase = PhMagic;
      else finish_header(1'b0, '0);
      return;
    end
    if (st_phase == PhLeadCmt) begin
      if (c == CharNl) st_phase = PhLead;
      return;
    end
    if (st_phase == PhMagic) begin
      if (c < Char4 || c > Char6) begin
        finish_header(1'b0, '0);
      end else begin
        st_kind  = 2'(c - Char4);
        st_phase = PhSep;
      end
      return;
    end
    fld      = (st_phase - PhSep) / 3;
    sub      = (st_phase - PhSep) % 3;
    last_fld = (st_kind == KindBitmap) ? FieldHeight : FieldMax;
    // comment inside the fields
    if (sub == 1) begin
      if (c == CharNl) st_phase = PhSep + 3 * fld;
      return;
    end
    // inside a number: a digit extends it, anything else ends it
    if (sub == 2) begin
      if (is_dig(c)) begin
        st_value = st_value * Radix + 32'(c - Char0);
        if (st_value > ValueMax) begin
          st_value = ValueMax;
          st_sat   = 1'b1;
        end
        return;
      end
      if (fld == last_fld) begin
        finish_header(1'b1, st_value);
        return;
      end
      if (fld == FieldWidth) st_width = st_value;
      else st_height = st_value;
      st_value = '0;
      fld++;
    end
    // separator position; the byte that ended a number lands here too
    if (is_sep(c)) begin
      st_phase = PhSep + 3 * fld;
    end else if (c == CharHash) begin
      st_phase = PhCmt + 3 * fld;
    end else if (is_dig(c)) begin
      st_value = 32'(c - Char0);
      st_phase = PhNum + 3 * fld;
    end else begin
      finish_header(1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endtask

  task automatic check_header(input pnm_out_t got);
    pnm_out_t want;
    if (expected_headers.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_headers.pop_front();
    if (got.header_ok !== want.header_ok)
      report_field("header_ok", 32'(want.header_ok), 32'(got.header_ok));
    if (got.image_kind !== want.image_kind)
      report_field("image_kind", 32'(want.image_kind), 32'(got.image_kind));
    if (got.image_width !== want.image_width)
      report_field("image_width", 32'(want.image_width), 32'(got.image_width));
    if (got.image_height !== want.image_height)
      report_field("image_height", 32'(want.image_height), 32'(got.image_height));
    if (got.max_value !== want.max_value)
      report_field("max_value", 32'(want.max_value), 32'(got.max_value));
    if (got.value_saturated !== want.value_saturated)
      report_field("value_saturated", 32'(want.value_saturated),
                   32'(got.value_saturated));
  endtask

  // ---------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic add_comment();
    logic [7:0] c;
    int unsigned n;
    stream_q.push_back(CharHash);
    n = $urandom_range(4);
    repeat (n) begin
      do c = 8'($urandom_range(255)); while (c == CharNl);
      stream_q.push_back(c);
    end
    stream_q.push_back(CharNl);
  endtask

  task automatic add_gap();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(1, 3);
    repeat (n) begin
      r = $urandom_range(5);
      case (r)
        0: add_comment();
        1: stream_q.push_back(CharTab);
        2: stream_q.push_back(CharNl);
        default: stream_q.push_back(CharSpace);
      endcase
    end
  endtask

  task automatic add_number();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(9);
    case (r)
      0: add_text("0");
      1: add_text("65535");
      2: add_text("65536");
      default: begin
        n = (r == 8) ? 5 : (r == 9) ? $urandom_range(6, 7) : $urandom_range(1, 4);
        repeat (n) stream_q.push_back(Char0 + 8'($urandom_range(9)));
      end
    endcase
  endtask

  // well-formed header with random layout and values
  task automatic build_header();
    logic [1:0]  kind;
    logic [7:0]  c;
    int unsigned n;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_comment();
    kind = 2'($urandom_range(2));
    stream_q.push_back(CharP);
    stream_q.push_back(Char4 + 8'(kind));
    if ($urandom_range(4) != 0) add_gap();
    add_number();
    add_gap();
    add_number();
    if (kind != KindBitmap) begin
      add_gap();
      add_number();
    end
    // how the last number ends: end of stream, a space, a non-digit byte, or a gap and random bytes
    case ($urandom_range(3))
      0: ;
      1: stream_q.push_back(CharSpace);
      2: begin
        do c = 8'($urandom_range(255)); while (is_dig(c));
        stream_q.push_back(c);
      end
      default: begin
        add_gap();
        n = $urandom_range(1, 3);
        repeat (n) stream_q.push_back(8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic close_stream(input bit drain);
    byte_slot_t s;
    bit         first;
    pnm_in_t    item;
    first = drain;
    foreach (stream_q[i]) begin
      item.data_byte     = stream_q[i];
      item.end_of_stream = 1'b0;
      s.item             = item;
      s.drain_first      = first;
      byte_feed.push_back(s);
      first = 1'b0;
    end
    item.data_byte     = 8'($urandom_range(255));
    item.end_of_stream = 1'b1;
    s.item             = item;
    s.drain_first      = first;
    byte_feed.push_back(s);
    stream_q.delete();
  endtask

  task automatic fill_byte_feed();
    int unsigned mode;
    int unsigned len;
    int unsigned pos;
    int unsigned stream_idx;
    // digit right after magic, end inside the last number, P6
    add_text("P67 8 9");
    close_stream(1'b0);
    // saturated width, last number ended by a stray byte, bytes after result
    add_text("P499999 0x!");
    close_stream(1'b0);
    // leading comment, then a carriage return after the magic, which is no separator
    stream_q.push_back(CharHash);
    stream_q.push_back(CharNl);
    add_text("P5");
    stream_q.push_back(CharCr);
    close_stream(1'b0);
    // whitespace before the magic
    stream_q.push_back(CharSpace);
    close_stream(1'b0);
    stream_idx = 0;
    while (byte_feed.size() < ItemCount) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        build_header();
      end else if (mode < 85) begin
        // broken header: truncated early or one byte replaced
        build_header();
        if ($urandom_range(1) == 0) begin
          len = $urandom_range(stream_q.size() - 1);
          while (stream_q.size() > len) void'(stream_q.pop_back());
        end else begin
          pos = $urandom_range(stream_q.size() - 1);
          stream_q[pos] = ($urandom_range(3) == 0) ? CharCr : 8'($urandom_range(255));
        end
      end else begin
        // noise, sometimes behind a magic letter
        if ($urandom_range(2) == 0) stream_q.push_back(CharP);
        len = $urandom_range(1, 6);
        repeat (len) stream_q.push_back(8'($urandom_range(255)));
      end
      close_stream(stream_idx % 50 == 25);
      stream_idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver and receiver stall, at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (byte_feed.size() != 0 &&
            !(byte_feed[0].drain_first && expected_headers.size() != 0) &&
            (calm || $urandom_range(99) >= IdlePct)) begin
          in_data_i  <= byte_feed[0].item;
          in_valid_i <= 1'b1;
          void'(byte_feed.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and watchdog, at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      // predict first so a same-edge result would still find its entry
      if (in_valid_i && !in_stall_o) begin
        predict_header_result(in_data_i);
        in_count++;
      end
      if (out_valid_o && !out_stall_i) check_header(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    fill_byte_feed();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (byte_feed.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_headers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (expected_headers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_headers.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
